// ===== rtl/adc_pkg.sv =====
// Shared types and constants for the antialiased disc coverage block.
`default_nettype none
package adc_pkg;

    // Fixed field widths
    localparam int RAD_W   = 8;
    localparam int FALL_W  = 15;
    localparam int PIX_W   = 8;
    localparam int DELTA_W = 11;   // signed half-pixel offset from center
    localparam int DSQ_W   = 20;   // full squared distance
    localparam int RING_W  = 18;   // squared distance of a pixel inside the disc
    localparam int ROOT_W  = 24;   // distance in pixels, Q.16
    localparam int REM_W   = 27;   // square root remainder
    localparam int NUM_W   = 24;   // radius minus distance, Q.16
    localparam int DIV_W   = 32;   // dividend, Q.24
    localparam int QUO_W   = 17;   // quotient bits, Q0.16 up to one
    localparam int COV_W   = 17;   // coverage in Q0.16
    localparam int IDX_W   = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FALLOFF = 2'd1;

    localparam logic [COV_W-1:0] COV_ONE = 17'h10000;

    // Pixel class decided by the front part
    typedef enum logic [1:0] {
        CLS_OUT,
        CLS_IN,
        CLS_RING
    } t_cls;

    // One queued item
    typedef struct packed {
        t_cls              cls;
        logic [RING_W-1:0] dsq;
    } t_item;

    // Effective geometry after clamping
    typedef struct packed {
        logic [RAD_W-1:0]  radius;
        logic [FALL_W-1:0] falloff;
    } t_geom;

endpackage
`default_nettype wire

// ===== rtl/adc_front.sv =====
// Front part: squared distance and inside/ring/outside classification.
`default_nettype none
module adc_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire adc_pkg::t_geom          i_geom,
    input  wire logic                    i_valid,
    input  wire logic [adc_pkg::PIX_W-1:0] i_pixel_x,
    input  wire logic [adc_pkg::PIX_W-1:0] i_pixel_y,
    input  wire logic                    i_enable,
    output logic                         o_push,
    output adc_pkg::t_item               o_item
);
    logic                                r_v1, r_v2;
    logic signed [adc_pkg::DELTA_W-1:0]  r_dx, r_dy;
    logic signed [adc_pkg::DELTA_W-1:0]  n_dx, n_dy, ctr;
    logic [adc_pkg::DSQ_W-1:0]           r_dsq;
    logic [31:0]                         r_fsq;
    logic [15:0]                         flat;
    logic [15:0]                         rsq;
    logic [17:0]                         rsq4;
    logic [33:0]                         dsq_sc;

    // Offsets from the disc center in half pixels
    always_comb begin
        ctr  = $signed({2'b00, i_geom.radius, 1'b1});
        n_dx = $signed({2'b00, i_pixel_x, 1'b0}) - ctr;
        n_dy = $signed({2'b00, i_pixel_y, 1'b0}) - ctr;
        flat = {i_geom.radius, 8'h00} - {1'b0, i_geom.falloff};
    end

    // Advance the two front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_enable) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enable) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_dsq <= adc_pkg::DSQ_W'(unsigned'(22'(r_dx * r_dx))
                                     + unsigned'(22'(r_dy * r_dy)));
            r_fsq <= flat * flat;
        end
    end

    // Classify against the disc edge and the inner flat area
    always_comb begin
        rsq    = {8'h00, i_geom.radius} * {8'h00, i_geom.radius};
        rsq4   = {rsq, 2'b00};
        dsq_sc = {r_dsq, 14'b0};
        o_push = r_v2 && i_enable;
        o_item.dsq = r_dsq[adc_pkg::RING_W-1:0];
        if ({14'b0, r_dsq} > {16'b0, rsq4}) begin
            o_item.cls = adc_pkg::CLS_OUT;
        end else if (i_geom.falloff == '0 || dsq_sc <= {2'b00, r_fsq}) begin
            o_item.cls = adc_pkg::CLS_IN;
        end else begin
            o_item.cls = adc_pkg::CLS_RING;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/adc_queue.sv =====
// Short item queue between the front and back parts.
`default_nettype none
module adc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire adc_pkg::t_item i_item,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_nonempty,
    output adc_pkg::t_item      o_item
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    adc_pkg::t_item  r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            do_pop;

    always_comb begin
        o_full     = r_cnt == (PW+1)'(DEPTH);
        o_nonempty = r_cnt != '0;
        o_item     = r_mem[r_rp];
        do_pop     = i_pop && o_nonempty;
    end

    // Track pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(do_pop);
        end
    end

    // Store an item
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

// ===== rtl/adc_back.sv =====
// Back part: square root, divide and smoothstep pipeline with output register.
`default_nettype none
module adc_back #(
    parameter int COVERAGE_FRAC_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire adc_pkg::t_geom              i_geom,
    input  wire logic                        i_nonempty,
    input  wire adc_pkg::t_item              i_item,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [COVERAGE_FRAC_BITS:0]      o_coverage
);
    localparam int SQ_N  = adc_pkg::ROOT_W;
    localparam int DV_N  = adc_pkg::QUO_W;
    localparam int OUT_W = COVERAGE_FRAC_BITS + 1;

    logic en;

    // Square root stages
    logic                          r_sv   [SQ_N];
    adc_pkg::t_cls                 r_scls [SQ_N];
    logic [adc_pkg::RING_W-1:0]    r_sd   [SQ_N];
    logic [adc_pkg::REM_W-1:0]     r_srem [SQ_N];
    logic [adc_pkg::ROOT_W-1:0]    r_sroot[SQ_N];

    // Numerator stage
    logic                          r_nv, r_nsat;
    adc_pkg::t_cls                 r_ncls;
    logic [adc_pkg::NUM_W-1:0]     r_num;

    // Divide stages
    logic                          r_dv   [DV_N];
    adc_pkg::t_cls                 r_dcls [DV_N];
    logic                          r_dsat [DV_N];
    logic [adc_pkg::DIV_W-1:0]     r_drem [DV_N];
    logic [adc_pkg::QUO_W-1:0]     r_dq   [DV_N];

    // Smoothstep stages
    logic                          r_tv, r_pv, r_ov;
    adc_pkg::t_cls                 r_tcls, r_pcls;
    logic [33:0]                   r_tsq;
    logic [17:0]                   r_k;
    logic [34:0]                   r_phi, r_plo;
    logic [OUT_W-1:0]              r_cov;

    logic [adc_pkg::QUO_W-1:0]     t_val;
    logic [adc_pkg::NUM_W-1:0]     rr, n_num;
    logic [51:0]                   psum;
    logic [19:0]                   c20;
    logic [adc_pkg::COV_W-1:0]     c16;
    logic [OUT_W-1:0]              cfmt;

    always_comb begin
        en    = !r_ov || !i_stall;
        o_pop = en && i_nonempty;
    end

    genvar j;
    generate
        for (j = 0; j < SQ_N; j++) begin : g_sq
            logic                       in_v;
            adc_pkg::t_cls              in_cls;
            logic [adc_pkg::RING_W-1:0] in_d;
            logic [adc_pkg::REM_W-1:0]  in_rem, sh, trial;
            logic [adc_pkg::ROOT_W-1:0] in_root;
            logic [1:0]                 pr;
            if (j == 0) begin : g_first
                assign in_v    = o_pop;
                assign in_cls  = i_item.cls;
                assign in_d    = i_item.dsq;
                assign in_rem  = '0;
                assign in_root = '0;
            end else begin : g_next
                assign in_v    = r_sv[j-1];
                assign in_cls  = r_scls[j-1];
                assign in_d    = r_sd[j-1];
                assign in_rem  = r_srem[j-1];
                assign in_root = r_sroot[j-1];
            end
            // Bring down the next two radicand bits; the low ones are zero
            if (2*j + 1 < adc_pkg::RING_W) begin : g_bits
                assign pr = in_d[adc_pkg::RING_W-1-2*j -: 2];
            end else begin : g_zero
                assign pr = 2'b00;
            end
            assign sh    = {in_rem[adc_pkg::REM_W-3:0], pr};
            assign trial = {1'b0, in_root, 2'b01};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_sv[j] <= 1'b0;
                else if (en)  r_sv[j] <= in_v;
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_scls[j] <= in_cls;
                    r_sd[j]   <= in_d;
                    if (sh >= trial) begin
                        r_srem[j]  <= sh - trial;
                        r_sroot[j] <= {in_root[adc_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        r_srem[j]  <= sh;
                        r_sroot[j] <= {in_root[adc_pkg::ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // Radius minus distance, and quotient overflow check
    always_comb begin
        rr    = {i_geom.radius, 16'h0000};
        n_num = rr > r_sroot[SQ_N-1] ? rr - r_sroot[SQ_N-1] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_nv <= 1'b0;
        else if (en)  r_nv <= r_sv[SQ_N-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ncls <= r_scls[SQ_N-1];
            r_num  <= n_num;
            r_nsat <= n_num >= {i_geom.falloff, 9'h000};
        end
    end

    genvar k;
    generate
        for (k = 0; k < DV_N; k++) begin : g_dv
            localparam int SH = DV_N - 1 - k;
            logic                      in_v, in_sat;
            adc_pkg::t_cls             in_cls;
            logic [adc_pkg::DIV_W-1:0] in_rem, dsr;
            logic [adc_pkg::QUO_W-1:0] in_q;
            if (k == 0) begin : g_first
                assign in_v   = r_nv;
                assign in_sat = r_nsat;
                assign in_cls = r_ncls;
                assign in_rem = {r_num, 8'h00};
                assign in_q   = '0;
            end else begin : g_next
                assign in_v   = r_dv[k-1];
                assign in_sat = r_dsat[k-1];
                assign in_cls = r_dcls[k-1];
                assign in_rem = r_drem[k-1];
                assign in_q   = r_dq[k-1];
            end
            assign dsr = adc_pkg::DIV_W'({17'b0, i_geom.falloff}) << SH;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_dv[k] <= 1'b0;
                else if (en)  r_dv[k] <= in_v;
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dsat[k] <= in_sat;
                    r_dcls[k] <= in_cls;
                    if (in_rem >= dsr) begin
                        r_drem[k] <= in_rem - dsr;
                        r_dq[k]   <= {in_q[adc_pkg::QUO_W-2:0], 1'b1};
                    end else begin
                        r_drem[k] <= in_rem;
                        r_dq[k]   <= {in_q[adc_pkg::QUO_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // Saturate t, then square it and form 3 - 2t
    always_comb begin
        if (r_dsat[DV_N-1] || r_dq[DV_N-1] > adc_pkg::COV_ONE) t_val = adc_pkg::COV_ONE;
        else t_val = r_dq[DV_N-1];
    end

    // Sum the partial products, force outside and inside classes, and fit the output format
    always_comb begin
        psum = {r_phi, 17'b0} + {17'b0, r_plo};
        c20  = psum[51:32];
        c16  = c20 > 20'(adc_pkg::COV_ONE) ? adc_pkg::COV_ONE : c20[adc_pkg::COV_W-1:0];
        case (r_pcls)
            adc_pkg::CLS_OUT:  c16 = '0;
            adc_pkg::CLS_IN:   c16 = adc_pkg::COV_ONE;
            default:           ;
        endcase
    end

    generate
        if (COVERAGE_FRAC_BITS >= 16) begin : g_wide
            assign cfmt = OUT_W'(c16) << (COVERAGE_FRAC_BITS - 16);
        end else begin : g_narrow
            logic [adc_pkg::COV_W-1:0] shr;
            assign shr  = c16 >> (16 - COVERAGE_FRAC_BITS);
            assign cfmt = shr[OUT_W-1:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_tv <= r_dv[DV_N-1];
            r_pv <= r_tv;
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tcls <= r_dcls[DV_N-1];
            r_tsq  <= t_val * t_val;
            r_k    <= 18'h30000 - {t_val, 1'b0};
            r_pcls <= r_tcls;
            r_phi  <= r_tsq[33:17] * r_k;
            r_plo  <= r_tsq[16:0] * r_k;
            r_cov  <= cfmt;
        end
    end

    assign o_valid    = r_ov;
    assign o_coverage = r_cov;
endmodule
`default_nettype wire

// ===== rtl/antialiased_disc_coverage.sv =====
// Top level: configuration registers, front part, item queue and back part.
// Pipeline: 48 register stages (2 front, 1 queue, 24 square root, 1 numerator,
// 17 divide, 3 smoothstep/output). Throughput: one item per cycle unless
// i_stall holds back a result; each square root and quotient bit has its own
// stage. Reset: synchronous, clears all valid bits and queue, and loads
// radius 8 and falloff 512 (Q7.8).
`default_nettype none
module antialiased_disc_coverage #(
    parameter int MAX_RADIUS         = 128,
    parameter int COVERAGE_FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [adc_pkg::PIX_W-1:0]     i_pixel_x,
    input  wire logic [adc_pkg::PIX_W-1:0]     i_pixel_y,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [COVERAGE_FRAC_BITS:0]        o_coverage,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [adc_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [adc_pkg::FALL_W-1:0]    i_cfg_data
);
    logic [adc_pkg::RAD_W-1:0]  r_radius;
    logic [adc_pkg::FALL_W-1:0] r_falloff;
    adc_pkg::t_geom             geom;
    adc_pkg::t_item             f_item, q_item;
    logic                       push, pop, q_full, q_nonempty;
    logic [15:0]                rad_full;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= 8'd8;
            r_falloff <= 15'd512;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                adc_pkg::REG_RADIUS:  r_radius  <= i_cfg_data[adc_pkg::RAD_W-1:0];
                adc_pkg::REG_FALLOFF: r_falloff <= i_cfg_data;
                default:              ;
            endcase
        end
    end

    // Clamp radius and falloff
    always_comb begin
        if (32'(r_radius) > MAX_RADIUS) geom.radius = adc_pkg::RAD_W'(MAX_RADIUS);
        else geom.radius = r_radius;
        rad_full = {geom.radius, 8'h00};
        if ({1'b0, r_falloff} >= rad_full) begin
            if (geom.radius == '0) geom.falloff = '0;
            else geom.falloff = adc_pkg::FALL_W'({geom.radius - 1'b1, 8'h00});
        end else begin
            geom.falloff = r_falloff;
        end
    end

    assign o_stall = q_full;

    adc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_valid   (i_valid),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_enable  (!q_full),
        .o_push    (push),
        .o_item    (f_item)
    );

    adc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (f_item),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_item     (q_item)
    );

    adc_back #(
        .COVERAGE_FRAC_BITS (COVERAGE_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_nonempty (q_nonempty),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_coverage (o_coverage)
    );
endmodule
`default_nettype wire
